// ===== rtl/core/gda_pkg.sv =====
// ----------------------------------------------------------------------------
// gda_pkg
// Shared types, codes, calendar tables and constant dividers for the
// Gregorian date arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gda_pkg;

	localparam int unsigned DEF_MAX_DELTA = 4095;
	localparam int unsigned DEF_YEAR_MAX  = 9999;

	localparam int unsigned DAY_W   = 5;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned DOY_W   = 9;
	localparam int unsigned CNT_W   = 12;
	localparam int unsigned DIST_W  = 23;
	localparam int unsigned R400_W  = 9;
	localparam int unsigned Q100_W  = 8;
	localparam int unsigned WDOY_W  = 14;

	localparam logic [DIST_W-1:0] DIST_MAX = 23'd4194303;
	localparam logic [DIST_W-1:0] DIST_NEG = 23'h7FFFFF;

	// p/100 = ((p>>2) * DIV25_K) >> DIV25_S, exact for p>>2 below 4681
	localparam logic [11:0] DIV25_K = 12'd2622;
	localparam int unsigned DIV25_S = 16;

	typedef enum logic [1:0] {
		OP_SET  = 2'd0,
		OP_ADD  = 2'd1,
		OP_SUB  = 2'd2,
		OP_DIST = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_INVALID   = 2'd1,
		ST_EARLIER   = 2'd2,
		ST_SATURATED = 2'd3
	} status_t;

	// leap test on year mod 400
	function automatic logic leap_r400(logic [R400_W-1:0] r);
		return (r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
	endfunction

	function automatic logic [DOY_W-1:0] year_len(logic lp);
		return lp ? 9'd366 : 9'd365;
	endfunction

	function automatic logic [DAY_W-1:0] month_len(logic [MONTH_W-1:0] m, logic lp);
		logic [DAY_W-1:0] len;
		unique case (m)
			4'd2:                         len = lp ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:      len = 5'd30;
			default:                      len = 5'd31;
		endcase
		return len;
	endfunction

	// days in the months before m, common year
	function automatic logic [DOY_W-1:0] days_before_month(logic [MONTH_W-1:0] m);
		logic [DOY_W-1:0] n;
		unique case (m)
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gregorian_date_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic_unit
// Holds a current Gregorian date and runs set, add days, subtract days and
// distance-to-target on it, one beat in and one result beat out per item.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | dir | handshake
//  --------+-------------------------------------------+-----+----------------
//  in      | op in_day in_month in_year day_count      | in  | in_valid/in_ready
//  out     | out_day out_month out_year day_of_year    | out | out_valid/out_ready
//          | leap distance status                      |     |
//
//  Set runs QT, RT, VT and DONE; distance adds QC, RC and DIF before DONE;
//  an invalid date goes from VT straight to DONE. Add and subtract walk the
//  years (S_YR, one boundary per cycle, plus a clamping pass when the year
//  range saturates), then the months of the final year (S_MON, up to 11).
//  Year split (p/100, p mod 400) goes through one shared constant multiplier.
//  in_ready is high only in idle; a held result stalls the finish step.
//  Reset loads 1 January 2000.
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_date_arithmetic_unit #(
	parameter int unsigned MAX_DELTA = gda_pkg::DEF_MAX_DELTA,
	parameter int unsigned YEAR_MAX  = gda_pkg::DEF_YEAR_MAX
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [1:0]                        op,
	input  wire logic [gda_pkg::DAY_W-1:0]         in_day,
	input  wire logic [gda_pkg::MONTH_W-1:0]       in_month,
	input  wire logic [gda_pkg::YEAR_W-1:0]        in_year,
	input  wire logic [gda_pkg::CNT_W-1:0]         day_count,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [gda_pkg::DAY_W-1:0]              out_day,
	output logic [gda_pkg::MONTH_W-1:0]            out_month,
	output logic [gda_pkg::YEAR_W-1:0]             out_year,
	output logic [gda_pkg::DOY_W-1:0]              day_of_year,
	output logic                                   leap,
	output logic signed [gda_pkg::DIST_W-1:0]      distance,
	output logic [1:0]                             status
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_QT,
		S_RT,
		S_VT,
		S_QC,
		S_RC,
		S_DIF,
		S_YR,
		S_MON,
		S_DONE
	} state_t;

	localparam logic [gda_pkg::YEAR_W-1:0] YMAX = gda_pkg::YEAR_W'(YEAR_MAX);
	localparam logic [15:0]                DMAX = 16'(MAX_DELTA);

	state_t                              state_q;

	// stored date
	logic [gda_pkg::DAY_W-1:0]           cur_day_q;
	logic [gda_pkg::MONTH_W-1:0]         cur_month_q;
	logic [gda_pkg::YEAR_W-1:0]          cur_year_q;
	logic [gda_pkg::R400_W-1:0]          cur_r400_q;
	logic [gda_pkg::DOY_W-1:0]           cur_doy_q;

	// item
	gda_pkg::op_t                        op_q;
	logic [gda_pkg::DAY_W-1:0]           td_q;
	logic [gda_pkg::MONTH_W-1:0]         tm_q;
	logic [gda_pkg::YEAR_W-1:0]          ty_q;

	// working registers
	logic [gda_pkg::Q100_W-1:0]          q_q;
	logic [gda_pkg::DIST_W-1:0]          dby_q;
	logic [gda_pkg::R400_W-1:0]          tr400_q;
	logic [gda_pkg::DIST_W-1:0]          acc_q;
	logic [gda_pkg::DIST_W-1:0]          numc_q;
	logic [gda_pkg::YEAR_W-1:0]          wy_q;
	logic [gda_pkg::R400_W-1:0]          wr_q;
	logic signed [gda_pkg::WDOY_W-1:0]   wdoy_q;
	logic [gda_pkg::MONTH_W-1:0]         wm_q;
	logic [gda_pkg::DIST_W-1:0]          dist_q;
	gda_pkg::status_t                    stat_q;

	// result register
	logic                                out_valid_q;
	logic [gda_pkg::DAY_W-1:0]           out_day_q;
	logic [gda_pkg::MONTH_W-1:0]         out_month_q;
	logic [gda_pkg::YEAR_W-1:0]          out_year_q;
	logic [gda_pkg::DOY_W-1:0]           out_doy_q;
	logic                                out_leap_q;
	logic [gda_pkg::DIST_W-1:0]          out_dist_q;
	gda_pkg::status_t                    out_stat_q;

	// shared year splitter
	logic [gda_pkg::YEAR_W-1:0]          sel_year;
	logic [gda_pkg::YEAR_W-1:0]          p_year;
	logic [11:0]                         x_year;
	logic [23:0]                         prod;
	logic [gda_pkg::DIST_W-1:0]          dby_c;
	logic [gda_pkg::YEAR_W-1:0]          pr400;
	logic [gda_pkg::R400_W-1:0]          r400_c;

	// target check
	logic                                leap_t;
	logic [gda_pkg::DOY_W-1:0]           doy_t;
	logic                                tgt_ok;

	// walk helpers
	logic [gda_pkg::CNT_W-1:0]           cnt_clamp;
	logic [gda_pkg::DOY_W-1:0]           ylen_cur;
	logic [gda_pkg::R400_W-1:0]          r_prev;
	logic [gda_pkg::R400_W-1:0]          r_next;
	logic [gda_pkg::DOY_W-1:0]           ylen_prev;
	logic [gda_pkg::DAY_W-1:0]           mlen_w;
	logic signed [gda_pkg::WDOY_W-1:0]   ylen_cur_s;
	logic signed [gda_pkg::WDOY_W-1:0]   ylen_prev_s;
	logic signed [gda_pkg::WDOY_W-1:0]   mlen_s;
	logic signed [23:0]                  diff;
	logic                                fire_out;

	assign in_ready = (state_q == S_IDLE);
	assign fire_out = !out_valid_q || out_ready;

	assign cnt_clamp = ({4'd0, day_count} > DMAX) ? gda_pkg::CNT_W'(MAX_DELTA) : day_count;

	// p = y-1; p/100 via multiply by reciprocal of 25 on p>>2
	assign sel_year = (state_q == S_QC || state_q == S_RC) ? cur_year_q : ty_q;
	assign p_year   = sel_year - 14'd1;
	assign x_year   = p_year[13:2];
	assign prod     = {12'd0, x_year} * {12'd0, gda_pkg::DIV25_K};

	// days before year: 365p + p/4 - p/100 + p/400
	assign dby_c = gda_pkg::DIST_W'(p_year) * 23'd365 + gda_pkg::DIST_W'(x_year)
		- gda_pkg::DIST_W'(q_q) + gda_pkg::DIST_W'(q_q[7:2]);
	assign pr400  = p_year - gda_pkg::YEAR_W'(q_q[7:2]) * 14'd400;
	assign r400_c = (pr400[8:0] == 9'd399) ? 9'd0 : pr400[8:0] + 9'd1;

	assign leap_t = gda_pkg::leap_r400(tr400_q);
	assign doy_t  = gda_pkg::days_before_month(tm_q) + gda_pkg::DOY_W'(td_q)
		+ gda_pkg::DOY_W'(leap_t && (tm_q > 4'd2));
	assign tgt_ok = (ty_q != '0) && (ty_q <= YMAX) && (tm_q != '0) && (tm_q <= 4'd12)
		&& (td_q != '0) && (td_q <= gda_pkg::month_len(tm_q, leap_t));

	assign ylen_cur    = gda_pkg::year_len(gda_pkg::leap_r400(wr_q));
	assign r_prev      = (wr_q == 9'd0) ? 9'd399 : wr_q - 9'd1;
	assign r_next      = (wr_q == 9'd399) ? 9'd0 : wr_q + 9'd1;
	assign ylen_prev   = gda_pkg::year_len(gda_pkg::leap_r400(r_prev));
	assign mlen_w      = gda_pkg::month_len(wm_q, gda_pkg::leap_r400(wr_q));
	assign ylen_cur_s  = $signed({5'd0, ylen_cur});
	assign ylen_prev_s = $signed({5'd0, ylen_prev});
	assign mlen_s      = $signed({9'd0, mlen_w});
	assign diff        = $signed({1'b0, acc_q}) - $signed({1'b0, numc_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_day_q   <= 5'd1;
			cur_month_q <= 4'd1;
			cur_year_q  <= 14'd2000;
			cur_r400_q  <= 9'd0;
			cur_doy_q   <= 9'd1;
			op_q        <= gda_pkg::OP_SET;
			td_q        <= '0;
			tm_q        <= '0;
			ty_q        <= '0;
			q_q         <= '0;
			dby_q       <= '0;
			tr400_q     <= '0;
			acc_q       <= '0;
			numc_q      <= '0;
			wy_q        <= '0;
			wr_q        <= '0;
			wdoy_q      <= '0;
			wm_q        <= '0;
			dist_q      <= '0;
			stat_q      <= gda_pkg::ST_OK;
			out_valid_q <= 1'b0;
			out_day_q   <= '0;
			out_month_q <= '0;
			out_year_q  <= '0;
			out_doy_q   <= '0;
			out_leap_q  <= 1'b0;
			out_dist_q  <= '0;
			out_stat_q  <= gda_pkg::ST_OK;
		end else begin
			// the finish step reloads the result register on its own
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q   <= gda_pkg::op_t'(op);
						td_q   <= in_day;
						tm_q   <= in_month;
						ty_q   <= in_year;
						dist_q <= '0;
						stat_q <= gda_pkg::ST_OK;
						wy_q   <= cur_year_q;
						wr_q   <= cur_r400_q;
						if (gda_pkg::op_t'(op) == gda_pkg::OP_ADD) begin
							wdoy_q  <= $signed({5'd0, cur_doy_q}) + $signed({2'd0, cnt_clamp});
							state_q <= S_YR;
						end else if (gda_pkg::op_t'(op) == gda_pkg::OP_SUB) begin
							wdoy_q  <= $signed({5'd0, cur_doy_q}) - $signed({2'd0, cnt_clamp});
							state_q <= S_YR;
						end else begin
							state_q <= S_QT;
						end
					end
				end
				S_QT: begin
					q_q     <= prod[23:16];
					state_q <= S_RT;
				end
				S_RT: begin
					dby_q   <= dby_c;
					tr400_q <= r400_c;
					state_q <= S_VT;
				end
				S_VT: begin
					acc_q <= dby_q + gda_pkg::DIST_W'(doy_t);
					if (!tgt_ok) begin
						stat_q  <= gda_pkg::ST_INVALID;
						state_q <= S_DONE;
					end else if (op_q == gda_pkg::OP_SET) begin
						cur_day_q   <= td_q;
						cur_month_q <= tm_q;
						cur_year_q  <= ty_q;
						cur_r400_q  <= tr400_q;
						cur_doy_q   <= doy_t;
						state_q     <= S_DONE;
					end else begin
						state_q <= S_QC;
					end
				end
				S_QC: begin
					q_q     <= prod[23:16];
					state_q <= S_RC;
				end
				S_RC: begin
					numc_q  <= dby_c + gda_pkg::DIST_W'(cur_doy_q);
					state_q <= S_DIF;
				end
				S_DIF: begin
					if (diff[23]) begin
						dist_q <= gda_pkg::DIST_NEG;
						stat_q <= gda_pkg::ST_EARLIER;
					end else if (diff[22:0] > gda_pkg::DIST_MAX) begin
						dist_q <= gda_pkg::DIST_MAX;
						stat_q <= gda_pkg::ST_SATURATED;
					end else begin
						dist_q <= diff[22:0];
					end
					state_q <= S_DONE;
				end
				S_YR: begin
					// one year boundary per cycle; clamping leaves the walk on its next pass
					if (op_q == gda_pkg::OP_ADD && wdoy_q > ylen_cur_s) begin
						if (wy_q == YMAX) begin
							wdoy_q <= ylen_cur_s;
							stat_q <= gda_pkg::ST_SATURATED;
						end else begin
							wdoy_q <= wdoy_q - ylen_cur_s;
							wy_q   <= wy_q + 14'd1;
							wr_q   <= r_next;
						end
					end else if (op_q == gda_pkg::OP_SUB && wdoy_q < 14'sd1) begin
						if (wy_q == 14'd1) begin
							wdoy_q <= 14'sd1;
							stat_q <= gda_pkg::ST_SATURATED;
						end else begin
							wdoy_q <= wdoy_q + ylen_prev_s;
							wy_q   <= wy_q - 14'd1;
							wr_q   <= r_prev;
						end
					end else begin
						cur_doy_q <= wdoy_q[8:0];
						wm_q      <= 4'd1;
						state_q   <= S_MON;
					end
				end
				S_MON: begin
					if (wm_q != 4'd12 && wdoy_q > mlen_s) begin
						wdoy_q <= wdoy_q - mlen_s;
						wm_q   <= wm_q + 4'd1;
					end else begin
						cur_day_q   <= wdoy_q[4:0];
						cur_month_q <= wm_q;
						cur_year_q  <= wy_q;
						cur_r400_q  <= wr_q;
						state_q     <= S_DONE;
					end
				end
				S_DONE: begin
					if (fire_out) begin
						out_valid_q <= 1'b1;
						out_day_q   <= cur_day_q;
						out_month_q <= cur_month_q;
						out_year_q  <= cur_year_q;
						out_doy_q   <= cur_doy_q;
						out_leap_q  <= gda_pkg::leap_r400(cur_r400_q);
						out_dist_q  <= dist_q;
						out_stat_q  <= stat_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign out_day     = out_day_q;
	assign out_month   = out_month_q;
	assign out_year    = out_year_q;
	assign day_of_year = out_doy_q;
	assign leap        = out_leap_q;
	assign distance    = $signed(out_dist_q);
	assign status      = out_stat_q;

`ifndef ASSERT_OFF
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while an item is in flight");

	a_r400_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_r400_q < 9'd400) && (wr_q < 9'd400))
		else $error("year mod 400 tracker out of range");

	a_earlier_dist: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == gda_pkg::ST_EARLIER) |-> (distance == -23'sd1))
		else $error("earlier target without distance of -1");

	a_doy_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (day_of_year != 9'd0 && day_of_year <= 9'd366
			&& out_day != 5'd0 && out_month != 4'd0 && out_month <= 4'd12))
		else $error("result date out of range");
`endif

endmodule

`default_nettype wire
